### design/pip_pkg.sv
// Shared types, constants and helper functions for the point-in-polygon test block.
package pip_pkg;

   // Signed width that holds any coordinate difference, including the ray end x
   localparam int DIFF_BITS  = 15;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   // Far end of the horizontal test ray
   localparam logic signed [DIFF_BITS-1:0] RAY_END_X = DIFF_BITS'(9999);

   // A polygon needs at least this many vertices
   localparam int MIN_POLY_VERTICES = 3;

   // Request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Orientation of an ordered point triple
   typedef enum logic [1:0] {
      ORIENT_COL = 2'd0,
      ORIENT_POS = 2'd1,
      ORIENT_NEG = 2'd2
   } orient_type;

   // Per-edge verdict handed from the edge evaluator to the sequencer
   typedef struct packed {
      logic meet;
      logic collinear;
      logic in_box;
   } edge_res_type;

   // Orientation code from the sign of a cross product
   function automatic orient_type orient_of(input logic signed [CROSS_BITS-1:0] v);
      orient_type o;
      priority if (v == '0) begin
         o = ORIENT_COL;
      end else if (v[CROSS_BITS-1]) begin
         o = ORIENT_NEG;
      end else begin
         o = ORIENT_POS;
      end
      return o;
   endfunction

   // Orientation of (point, ray end, vertex): set by the vertex y against the ray y
   function automatic orient_type ray_side(input logic signed [DIFF_BITS-1:0] vy,
                                           input logic signed [DIFF_BITS-1:0] py);
      orient_type o;
      priority if (vy == py) begin
         o = ORIENT_COL;
      end else if (vy > py) begin
         o = ORIENT_NEG;
      end else begin
         o = ORIENT_POS;
      end
      return o;
   endfunction

endpackage

### design/pip_vertex_mem.sv
// Vertex store: x and y arrays with one write port and one registered read port.
module pip_vertex_mem #(
   parameter int DEPTH      = 64,
   parameter int COORD_BITS = 13
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [COORD_BITS-1:0]         wr_x,
   input  logic [COORD_BITS-1:0]         wr_y,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [COORD_BITS-1:0]         rd_x,
   output logic [COORD_BITS-1:0]         rd_y
);

   logic [COORD_BITS-1:0] vertex_x_ff [DEPTH];
   logic [COORD_BITS-1:0] vertex_y_ff [DEPTH];
   logic [COORD_BITS-1:0] rd_x_ff;
   logic [COORD_BITS-1:0] rd_y_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_x_ff[wr_addr] <= wr_x;
         vertex_y_ff[wr_addr] <= wr_y;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_x_ff <= vertex_x_ff[rd_addr];
         rd_y_ff <= vertex_y_ff[rd_addr];
      end
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

### design/pip_edge_eval.sv
// Two-stage edge evaluator: tests one polygon edge against the horizontal ray per cycle.
module pip_edge_eval #(
   parameter int COORD_BITS = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [COORD_BITS-1:0]   s1_x,
   input  logic [COORD_BITS-1:0]   s1_y,
   input  logic [COORD_BITS-1:0]   s2_x,
   input  logic [COORD_BITS-1:0]   s2_y,
   input  logic [COORD_BITS-1:0]   pt_x,
   input  logic [COORD_BITS-1:0]   pt_y,
   output logic                    out_valid,
   output pip_pkg::edge_res_type   out_res
);

   localparam int DB  = pip_pkg::DIFF_BITS;
   localparam int PB  = pip_pkg::PROD_BITS;
   localparam int CB  = pip_pkg::CROSS_BITS;
   localparam int PAD = DB - COORD_BITS;

   // Stage 1: differences and products
   logic signed [DB-1:0] e_s1y, e_s2x, e_s2y, e_s1x, e_px, e_py;
   logic signed [DB-1:0] dy_s, dx_s, dx_p, dx_r, dy_p;
   logic signed [PB-1:0] prod_a_in, prod_r_in, prod_b_in;
   logic signed [PB-1:0] prod_a_ff, prod_r_ff, prod_b_ff;
   pip_pkg::orient_type  d3_in, d4_in, d3_ff, d4_ff;
   logic                 t3_in, t4_in, box_in, t3_ff, t4_ff, box_ff;
   logic                 v1_ff;

   // Stage 2: cross products and verdict
   logic signed [CB-1:0]  cross_p, cross_r;
   pip_pkg::orient_type   d1, d2;
   pip_pkg::edge_res_type res_in;
   pip_pkg::edge_res_type res_ff;
   logic                  v2_ff;

   always_comb begin
      e_s1x = $signed({{PAD{1'b0}}, s1_x});
      e_s1y = $signed({{PAD{1'b0}}, s1_y});
      e_s2x = $signed({{PAD{1'b0}}, s2_x});
      e_s2y = $signed({{PAD{1'b0}}, s2_y});
      e_px  = $signed({{PAD{1'b0}}, pt_x});
      e_py  = $signed({{PAD{1'b0}}, pt_y});

      dy_s = e_s2y - e_s1y;
      dx_s = e_s2x - e_s1x;
      dx_p = e_px - e_s2x;
      dx_r = pip_pkg::RAY_END_X - e_s2x;
      dy_p = e_py - e_s2y;

      // Shared second term serves both the point and the ray end
      prod_a_in = PB'(dy_s) * PB'(dx_p);
      prod_r_in = PB'(dy_s) * PB'(dx_r);
      prod_b_in = PB'(dx_s) * PB'(dy_p);

      // Ray side of each vertex; the ray end lies right of every vertex
      d3_in  = pip_pkg::ray_side(e_s1y, e_py);
      d4_in  = pip_pkg::ray_side(e_s2y, e_py);
      t3_in  = (s1_y == pt_y) && (s1_x >= pt_x);
      t4_in  = (s2_y == pt_y) && (s2_x >= pt_x);

      // Point within the edge's bounding box
      box_in = (pt_x >= s1_x || pt_x >= s2_x) && (pt_x <= s1_x || pt_x <= s2_x) &&
               (pt_y >= s1_y || pt_y >= s2_y) && (pt_y <= s1_y || pt_y <= s2_y);
   end

   always_comb begin
      cross_p = CB'(prod_a_ff) - CB'(prod_b_ff);
      cross_r = CB'(prod_r_ff) - CB'(prod_b_ff);
      d1      = pip_pkg::orient_of(cross_p);
      d2      = pip_pkg::orient_of(cross_r);

      res_in.meet      = ((d1 != d2) && (d3_ff != d4_ff)) ||
                         ((d1 == pip_pkg::ORIENT_COL) && box_ff) || t3_ff || t4_ff;
      res_in.collinear = (d1 == pip_pkg::ORIENT_COL);
      res_in.in_box    = box_ff;
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      prod_a_ff <= prod_a_in;
      prod_r_ff <= prod_r_in;
      prod_b_ff <= prod_b_in;
      d3_ff     <= d3_in;
      d4_ff     <= d4_in;
      t3_ff     <= t3_in;
      t4_ff     <= t4_in;
      box_ff    <= box_in;
      res_ff    <= res_in;
   end

   assign out_valid = v2_ff;
   assign out_res   = res_ff;

endmodule

### design/point_in_polygon_test.sv
// Top level: point-in-polygon test by ray casting over a stored vertex list.
// Vertex write word: no response word; one write a cycle while the block is idle.
// Query with n >= 3 vertices: n+1 vertex memory reads, one edge a cycle; the read walk sets
//   the pace, and no new request word is taken until the response word is loaded.
// Query with fewer than three vertices: answered outside without reading the vertex store.
// Reset clears control state and vertex_count; the vertex store keeps no reset value.
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [6:0]              csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic [5:0]              req_vertex_index,
   input  logic [COORD_BITS-1:0]   req_coord_x,
   input  logic [COORD_BITS-1:0]   req_coord_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_inside_res
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [6:0]              vertex_count_ff, vertex_count_in;
   logic [NW-1:0]           n_ff, n_in, n_now;
   logic [COORD_BITS-1:0]   pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [NW-1:0]           rd_cnt_ff, rd_cnt_in;
   logic                    rd_vld_ff, rd_vld_in, rd_first_ff, rd_first_in;
   logic [COORD_BITS-1:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [NW-1:0]           ret_cnt_ff, ret_cnt_in;
   logic                    hit_ff, hit_in, hit_val_ff, hit_val_in;
   logic                    parity_ff, parity_in;
   logic                    res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in, rsp_res_ff, rsp_res_in;

   logic                    req_acc;
   logic                    wr_en;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [COORD_BITS-1:0]   rd_x, rd_y;
   logic                    edge_in_valid;
   logic                    edge_out_valid;
   pip_pkg::edge_res_type   edge_res;
   logic                    last_edge;
   logic                    hit_next, hit_val_next, parity_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;

   // Vertex writes; slots beyond the store are dropped
   assign wr_en = req_acc && (req_func == pip_pkg::FUNC_WRITE) &&
                  (32'(req_vertex_index) < MAX_VERTICES);

   // Effective vertex count, clamped to the store depth
   assign n_now = (32'(vertex_count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                         : NW'(vertex_count_ff);

   // Read walk: addresses 0 .. n-1, then vertex 0 again to close the polygon
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = (rd_cnt_ff == n_ff) ? '0 : rd_cnt_ff[AW-1:0];

   assign edge_in_valid = rd_vld_ff && !rd_first_ff;

   pip_vertex_mem #(
      .DEPTH      (MAX_VERTICES),
      .COORD_BITS (COORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_vertex_index)),
      .wr_x    (req_coord_x),
      .wr_y    (req_coord_y),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   pip_edge_eval #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (edge_in_valid),
      .s1_x      (prev_x_ff),
      .s1_y      (prev_y_ff),
      .s2_x      (rd_x),
      .s2_y      (rd_y),
      .pt_x      (pt_x_ff),
      .pt_y      (pt_y_ff),
      .out_valid (edge_out_valid),
      .out_res   (edge_res)
   );

   // Running verdict including the edge retiring this cycle
   always_comb begin
      hit_next     = hit_ff || (edge_res.meet && edge_res.collinear);
      hit_val_next = hit_ff ? hit_val_ff : edge_res.in_box;
      parity_next  = parity_ff ^ (edge_res.meet && !edge_res.collinear);
      last_edge    = edge_out_valid && (ret_cnt_ff == n_ff - NW'(1));
   end

   // Sequencer next state
   always_comb begin
      state_in        = state_ff;
      vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;
      n_in            = n_ff;
      pt_x_in         = pt_x_ff;
      pt_y_in         = pt_y_ff;
      rd_cnt_in       = rd_cnt_ff;
      rd_vld_in       = rd_en;
      rd_first_in     = rd_en && (rd_cnt_ff == '0);
      prev_x_in       = rd_vld_ff ? rd_x : prev_x_ff;
      prev_y_in       = rd_vld_ff ? rd_y : prev_y_ff;
      ret_cnt_in      = ret_cnt_ff;
      hit_in          = hit_ff;
      hit_val_in      = hit_val_ff;
      parity_in       = parity_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_res_in      = rsp_res_ff;

      // Retire edge verdicts
      if (edge_out_valid) begin
         ret_cnt_in = ret_cnt_ff + NW'(1);
         hit_in     = hit_next;
         hit_val_in = hit_val_next;
         parity_in  = parity_next;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_func == pip_pkg::FUNC_QUERY)) begin
               pt_x_in    = req_coord_x;
               pt_y_in    = req_coord_y;
               n_in       = n_now;
               rd_cnt_in  = '0;
               ret_cnt_in = '0;
               hit_in     = 1'b0;
               hit_val_in = 1'b0;
               parity_in  = 1'b0;
               if (32'(n_now) < pip_pkg::MIN_POLY_VERTICES) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + NW'(1);
            if (rd_cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (last_edge) begin
               res_in   = hit_next ? hit_val_next : parity_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      n_ff        <= n_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_first_ff <= rd_first_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      ret_cnt_ff  <= ret_cnt_in;
      hit_ff      <= hit_in;
      hit_val_ff  <= hit_val_in;
      parity_ff   <= parity_in;
      res_ff      <= res_in;
      rsp_res_ff  <= rsp_res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_res_ff;

`ifndef NO_ASSERTIONS
   // Edge verdicts only arrive while a query walks the polygon
   a_edge_in_walk: assert property (@(posedge clock) disable iff (reset)
      edge_out_valid |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("edge verdict outside a query walk");

   // Retire count stays below the edge count while draining
   a_retire_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (ret_cnt_ff < n_ff))
      else $error("retire count overran edge count");

   // Read counter never passes the closing read
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_cnt_ff <= n_ff))
      else $error("read counter overran vertex count");

   // Leaving DONE presents a response word
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response word not loaded on leaving DONE");

   // A degenerate polygon answers outside at once
   a_small_poly: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_func == pip_pkg::FUNC_QUERY &&
       32'(n_now) < pip_pkg::MIN_POLY_VERTICES)
      |=> (state_ff == ST_DONE && !res_ff))
      else $error("degenerate polygon query not answered outside");
`endif

endmodule
